/* sv/pdh_pkg.sv */
// ----------------------------------------------------------------------------
// pdh_pkg: shared types and constants
// Field widths, register indexes and the controller/datapath command word.
// ----------------------------------------------------------------------------
package pdh_pkg;

   localparam int POS_W    = 24;   // signed Q12.12 position
   localparam int CELL_W   = 23;   // unsigned Q11.12 box length / bin width
   localparam int BINS_W   = 9;
   localparam int WGT_W    = 2;
   localparam int HIT_W    = 8;
   localparam int OUT_W    = 32;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int NUM_W    = 26;   // folding numerator width
   localparam int MAG_W    = 24;   // folded component magnitude
   localparam int R2_W     = 50;   // squared distance
   localparam int CNT_W    = 5;
   localparam int DIV_STEPS = NUM_W;

   localparam logic [2:0] REG_CELL_X      = 3'd0;
   localparam logic [2:0] REG_CELL_Y      = 3'd1;
   localparam logic [2:0] REG_CELL_Z      = 3'd2;
   localparam logic [2:0] REG_BIN_WIDTH   = 3'd3;
   localparam logic [2:0] REG_BINS_IN_USE = 3'd4;
   localparam logic [2:0] REG_PAIR_WEIGHT = 3'd5;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic [CELL_W-1:0] cell_x;
      logic [CELL_W-1:0] cell_y;
      logic [CELL_W-1:0] cell_z;
      logic [CELL_W-1:0] bin_width;
      logic [BINS_W-1:0] bins_in_use;
      logic [WGT_W-1:0]  pair_weight;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic fold_fin;
      logic square;
      logic sum;
      logic mul_nb;
      logic mul;
      logic cmp_nb;
      logic cmp;
      logic mem_rd;
      logic finish;
      logic clr_step;
   } cmd_type;

   typedef struct packed {
      logic op;
      logic hit_ok;
      logic clr_last;
   } stat_type;

endpackage

/* sv/pdh_csr.sv */
// ----------------------------------------------------------------------------
// pdh_csr: configuration register file
// APB-style write/read of the box lengths, bin width, bin count and weight.
// ----------------------------------------------------------------------------
module pdh_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [pdh_pkg::ADDR_W-1:0]  paddr,
   input  logic [pdh_pkg::DATA_W-1:0]  pwdata,
   output logic [pdh_pkg::DATA_W-1:0]  prdata,
   output logic                        pready,
   output pdh_pkg::cfg_type            cfg
);
   import pdh_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] idx;
   logic       wr;

   assign idx    = paddr[4:2];
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         case (idx)
            REG_CELL_X:      cfg_in.cell_x      = pwdata[CELL_W-1:0];
            REG_CELL_Y:      cfg_in.cell_y      = pwdata[CELL_W-1:0];
            REG_CELL_Z:      cfg_in.cell_z      = pwdata[CELL_W-1:0];
            REG_BIN_WIDTH:   cfg_in.bin_width   = pwdata[CELL_W-1:0];
            REG_BINS_IN_USE: cfg_in.bins_in_use = pwdata[BINS_W-1:0];
            REG_PAIR_WEIGHT: cfg_in.pair_weight = pwdata[WGT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_CELL_X:      prdata = DATA_W'(cfg_ff.cell_x);
         REG_CELL_Y:      prdata = DATA_W'(cfg_ff.cell_y);
         REG_CELL_Z:      prdata = DATA_W'(cfg_ff.cell_z);
         REG_BIN_WIDTH:   prdata = DATA_W'(cfg_ff.bin_width);
         REG_BINS_IN_USE: prdata = DATA_W'(cfg_ff.bins_in_use);
         REG_PAIR_WEIGHT: prdata = DATA_W'(cfg_ff.pair_weight);
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cell_x      <= CELL_W'(4096);
         cfg_ff.cell_y      <= CELL_W'(4096);
         cfg_ff.cell_z      <= CELL_W'(4096);
         cfg_ff.bin_width   <= CELL_W'(256);
         cfg_ff.bins_in_use <= BINS_W'(256);
         cfg_ff.pair_weight <= WGT_W'(1);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* sv/pdh_ctrl.sv */
// ----------------------------------------------------------------------------
// pdh_ctrl: sequencing state machine
// Steps an add word through fold, square, bin search and histogram update, or a read word through a bin read.
// ----------------------------------------------------------------------------
module pdh_ctrl #(
   parameter int NUM_BINS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   input  pdh_pkg::stat_type  stat,
   output pdh_pkg::cmd_type   cmd
);
   import pdh_pkg::*;

   localparam int KW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

   typedef enum logic [12:0] {
      S_CLR  = 13'b0000000000001,
      S_IDLE = 13'b0000000000010,
      S_DIV  = 13'b0000000000100,
      S_FIN  = 13'b0000000001000,
      S_SQ   = 13'b0000000010000,
      S_SUM  = 13'b0000000100000,
      S_MULN = 13'b0000001000000,
      S_CMPN = 13'b0000010000000,
      S_MUL  = 13'b0000100000000,
      S_CMP  = 13'b0001000000000,
      S_RD   = 13'b0010000000000,
      S_WAIT = 13'b0100000000000,
      S_DONE = 13'b1000000000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             vld_ff, vld_in;
   logic             slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = vld_ff;
   assign slot_free = !vld_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      vld_in   = vld_ff && !rsp_ready;
      cmd      = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clr_step = 1'b1;
            if (stat.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = stat.op ? S_RD : S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_STEPS - 1)) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.fold_fin = 1'b1;
            state_in     = S_SQ;
         end
         S_SQ: begin
            cmd.square = 1'b1;
            state_in   = S_SUM;
         end
         S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = S_MULN;
         end
         S_MULN: begin
            cmd.mul_nb = 1'b1;
            state_in   = S_CMPN;
         end
         S_CMPN: begin
            cmd.cmp_nb = 1'b1;
            cnt_in     = '0;
            state_in   = stat.hit_ok ? S_MUL : S_DONE;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_CMP;
         end
         S_CMP: begin
            cmd.cmp  = 1'b1;
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff == CNT_W'(KW - 1)) ? S_RD : S_MUL;
         end
         S_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_WAIT;
         end
         S_WAIT: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (slot_free) begin
               cmd.finish = 1'b1;
               vld_in     = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
         cnt_ff   <= '0;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         vld_ff   <= vld_in;
      end
   end

endmodule

/* sv/pdh_dpath.sv */
// ----------------------------------------------------------------------------
// pdh_dpath: fold, distance and histogram datapath
// Three remainder lanes, squares, bin search by multiply-compare, count RAM.
// ----------------------------------------------------------------------------
module pdh_dpath #(
   parameter int NUM_BINS   = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  pdh_pkg::cmd_type                  cmd,
   output pdh_pkg::stat_type                 stat,
   input  pdh_pkg::cfg_type                  cfg,
   input  logic                              req_operation,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_first_x,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_first_y,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_first_z,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_second_x,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_second_y,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_second_z,
   input  logic [pdh_pkg::HIT_W-1:0]         req_read_bin,
   output logic                              rsp_counted,
   output logic [pdh_pkg::HIT_W-1:0]         rsp_hit_bin,
   output logic [pdh_pkg::OUT_W-1:0]         rsp_bin_count
);
   import pdh_pkg::*;

   localparam int KW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int PW = KW + 1 + CELL_W;
   localparam logic [KW:0]   NB_MAX   = (KW+1)'(NUM_BINS);
   localparam logic [KW-1:0] CLR_LAST = KW'(NUM_BINS - 1);
   localparam logic [COUNT_BITS-1:0] CMAX = '1;

   // per-axis lane state
   logic signed [POS_W:0]   diff_ff [3];
   logic [NUM_W-1:0]        num_ff  [3];
   logic [NUM_W-1:0]        rem_ff  [3];
   logic                    neg_ff  [3];
   logic                    keep_ff [3];
   logic [MAG_W-1:0]        mag_ff  [3];
   logic [2*MAG_W-1:0]      sq_ff   [3];
   logic [CELL_W-1:0]       len     [3];
   logic signed [POS_W-1:0] fa      [3];
   logic signed [POS_W-1:0] sa      [3];

   logic                    op_ff;
   logic [HIT_W-1:0]        rb_ff;
   logic                    in_range_ff;
   logic [R2_W-1:0]         r2_ff;
   logic [KW:0]             cand_ff;
   logic                    cand_ok_ff;
   logic [PW-1:0]           p_ff;
   logic [KW-1:0]           k_ff;
   logic [KW-1:0]           bit_ff;
   logic                    counted_ff;
   logic [KW-1:0]           clr_ff;
   logic [COUNT_BITS-1:0]   rdata_ff;
   logic [COUNT_BITS-1:0]   mem [NUM_BINS];

   logic                    out_counted_ff;
   logic [HIT_W-1:0]        out_hit_ff;
   logic [OUT_W-1:0]        out_cnt_ff;

   logic [31:0]             biu32;
   logic [31:0]             rb32;
   logic [31:0]             rb_ext;
   logic [KW:0]             nb;
   logic [KW:0]             cand;
   logic                    pass;
   logic [R2_W-1:0]         psq;
   logic [KW-1:0]           rb_addr;
   logic [KW-1:0]           addr;
   logic [COUNT_BITS:0]     sum_w;
   logic [COUNT_BITS-1:0]   sat_cnt;
   logic [COUNT_BITS+OUT_W-1:0] sat_ext;
   logic [COUNT_BITS+OUT_W-1:0] rd_ext;
   logic [KW+HIT_W-1:0]     k_ext;

   assign len[0] = cfg.cell_x;
   assign len[1] = cfg.cell_y;
   assign len[2] = cfg.cell_z;
   assign fa[0]  = req_first_x;
   assign fa[1]  = req_first_y;
   assign fa[2]  = req_first_z;
   assign sa[0]  = req_second_x;
   assign sa[1]  = req_second_y;
   assign sa[2]  = req_second_z;

   assign biu32   = 32'(cfg.bins_in_use);
   assign nb      = (biu32 > 32'(NUM_BINS)) ? NB_MAX : biu32[KW:0];
   assign rb32    = 32'(req_read_bin);
   assign rb_ext  = 32'(rb_ff);
   assign rb_addr = rb_ext[KW-1:0];
   assign addr    = op_ff ? rb_addr : k_ff;
   assign cand    = cmd.mul_nb ? nb : {1'b0, k_ff | bit_ff};

   // test: (cand * width)^2 <= r2, products beyond 25 bits always exceed r2
   assign psq  = R2_W'(p_ff[24:0]) * R2_W'(p_ff[24:0]);
   assign pass = ((p_ff >> 25) == '0) && (psq <= r2_ff);

   assign sum_w   = {1'b0, rdata_ff} + (COUNT_BITS+1)'(cfg.pair_weight);
   assign sat_cnt = sum_w[COUNT_BITS] ? CMAX : sum_w[COUNT_BITS-1:0];
   assign sat_ext = {{OUT_W{1'b0}}, sat_cnt};
   assign rd_ext  = {{OUT_W{1'b0}}, rdata_ff};
   assign k_ext   = {{HIT_W{1'b0}}, k_ff};

   assign stat.op       = req_operation;
   assign stat.hit_ok   = !pass && (r2_ff != '0) && (cfg.bin_width != '0);
   assign stat.clr_last = (clr_ff == CLR_LAST);

   assign rsp_counted   = out_counted_ff;
   assign rsp_hit_bin   = out_hit_ff;
   assign rsp_bin_count = out_cnt_ff;

   // fold lanes: remainder of the folding numerator by twice the box length
   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin : lane
         logic signed [POS_W:0]   d;
         logic signed [NUM_W-1:0] td;
         logic signed [NUM_W-1:0] ls;
         logic [NUM_W-1:0]        t;
         logic [NUM_W-1:0]        dv;
         logic signed [POS_W:0]   v;
         logic signed [POS_W:0]   f;
         d  = {fa[i][POS_W-1], fa[i]} - {sa[i][POS_W-1], sa[i]};
         td = {d, 1'b0};
         ls = NUM_W'(len[i]);
         t  = {rem_ff[i][NUM_W-2:0], num_ff[i][NUM_W-1]};
         dv = {2'b00, len[i], 1'b0};
         v  = neg_ff[i] ? ((POS_W+1)'(len[i]) - rem_ff[i][POS_W:0])
                        : (rem_ff[i][POS_W:0] - (POS_W+1)'(len[i]));
         f  = keep_ff[i] ? diff_ff[i] : (v >>> 1);
         if (cmd.load) begin
            diff_ff[i] <= d;
            neg_ff[i]  <= (td < -ls);
            keep_ff[i] <= (len[i] == '0) || !((td < -ls) || (td > ls));
            num_ff[i]  <= (td < -ls) ? NUM_W'(ls - td) : NUM_W'(td + ls);
            rem_ff[i]  <= '0;
         end
         if (cmd.div_step) begin
            rem_ff[i] <= (t >= dv) ? (t - dv) : t;
            num_ff[i] <= {num_ff[i][NUM_W-2:0], 1'b0};
         end
         if (cmd.fold_fin) begin
            mag_ff[i] <= f[POS_W] ? MAG_W'(-f) : MAG_W'(f);
         end
         if (cmd.square) begin
            sq_ff[i] <= mag_ff[i] * mag_ff[i];
         end
      end
   end

   // bin search and item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req_operation;
         rb_ff       <= req_read_bin;
         in_range_ff <= (rb32 < 32'(NUM_BINS));
         counted_ff  <= 1'b0;
         k_ff        <= '0;
      end
      if (cmd.sum) begin
         r2_ff <= R2_W'(sq_ff[0]) + R2_W'(sq_ff[1]) + R2_W'(sq_ff[2]);
      end
      if (cmd.mul_nb || cmd.mul) begin
         cand_ff    <= cand;
         cand_ok_ff <= (cand < nb);
         p_ff       <= PW'(cand) * PW'(cfg.bin_width);
      end
      if (cmd.cmp_nb) begin
         counted_ff <= stat.hit_ok;
         bit_ff     <= KW'(1) << (KW - 1);
      end
      if (cmd.cmp) begin
         if (pass && cand_ok_ff) k_ff <= cand_ff[KW-1:0];
         bit_ff <= bit_ff >> 1;
      end
      if (cmd.finish) begin
         if (op_ff == OP_READ) begin
            out_counted_ff <= 1'b0;
            out_hit_ff     <= rb_ff;
            out_cnt_ff     <= in_range_ff ? rd_ext[OUT_W-1:0] : '0;
         end else begin
            out_counted_ff <= counted_ff;
            out_hit_ff     <= counted_ff ? k_ext[HIT_W-1:0] : '0;
            out_cnt_ff     <= counted_ff ? sat_ext[OUT_W-1:0] : '0;
         end
      end
   end

   // count RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) rdata_ff <= mem[addr];
      if (cmd.clr_step) begin
         mem[clr_ff] <= '0;
      end else if (cmd.finish) begin
         if (op_ff == OP_READ) begin
            if (in_range_ff) mem[addr] <= '0;
         end else if (counted_ff) begin
            mem[addr] <= sat_cnt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

endmodule

/* sv/pair_distance_histogram_pbc.sv */
// ----------------------------------------------------------------------------
// pair_distance_histogram_pbc: periodic pair-distance histogram
// Folds pair differences into the box, bins the distance, counts per bin.
// ----------------------------------------------------------------------------
// Sequence: an add word passes load, 26 remainder steps per axis, fold,
//   square, sum and the cutoff compare, then, inside the cutoff, the bin
//   search and RAM read; a read word goes straight to the RAM read.
// Throughput: one word at a time; the next word is taken once the current
//   one has moved to the result register.
// Reset: synchronous; control and configuration registers return to
//   defaults and the count RAM is swept to zero, accepting no word meanwhile.
module pair_distance_histogram_pbc #(
   parameter int NUM_BINS   = 256,
   parameter int COUNT_BITS = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // input word channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_operation,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_first_x,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_first_y,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_first_z,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_second_x,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_second_y,
   input  logic signed [pdh_pkg::POS_W-1:0]  req_second_z,
   input  logic [pdh_pkg::HIT_W-1:0]         req_read_bin,
   // result word channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_counted,
   output logic [pdh_pkg::HIT_W-1:0]         rsp_hit_bin,
   output logic [pdh_pkg::OUT_W-1:0]         rsp_bin_count,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [pdh_pkg::ADDR_W-1:0]        paddr,
   input  logic [pdh_pkg::DATA_W-1:0]        pwdata,
   output logic [pdh_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);
   import pdh_pkg::*;

   cfg_type  cfg;
   cmd_type  cmd;
   stat_type stat;

   // Hold box, bin and weight settings; the user must write them only between words, the block does not enforce it.
   pdh_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sweep the RAM clear after reset, then sequence each word: fold, square, search, RAM update, or a bin read.
   pdh_ctrl #(
      .NUM_BINS (NUM_BINS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Advance the arithmetic and the count RAM on controller commands.
   pdh_dpath #(
      .NUM_BINS   (NUM_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .cfg           (cfg),
      .req_operation (req_operation),
      .req_first_x   (req_first_x),
      .req_first_y   (req_first_y),
      .req_first_z   (req_first_z),
      .req_second_x  (req_second_x),
      .req_second_y  (req_second_y),
      .req_second_z  (req_second_z),
      .req_read_bin  (req_read_bin),
      .rsp_counted   (rsp_counted),
      .rsp_hit_bin   (rsp_hit_bin),
      .rsp_bin_count (rsp_bin_count)
   );

endmodule
